// ===== hdl/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// Table linear interpolator package
// Shared types, codes and constants of the table linear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

  // Default depth of the abscissa and ordinate table.
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  // Width of the configuration registers and of the register index.
  localparam int unsigned CFG_W = 9;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [CFG_W-1:0] POINTS_RESET = 9'd2;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 9'd2;
  localparam logic [CFG_W-1:0] WINDOW_MIN = 9'd2;

  // The quotient is needed to 35 bits: anything from 2^34 upwards saturates.
  localparam int unsigned DIV_BITS = 35;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_BITS-1:0] QUOT_LIMIT = 35'h4_0000_0000;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } tli_op_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_POINTS_IN_USE = 1'b0,
    REG_WINDOW_POINTS = 1'b1
  } tli_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_BISECT,
    ST_OFFSET,
    ST_READ_LO,
    ST_READ_HI,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } tli_state_e;

  typedef struct packed {
    logic              opcode;
    logic [7:0]        entry_index;
    logic signed [31:0] abscissa_value;
    logic signed [31:0] ordinate_value;
    logic signed [31:0] query_point;
  } tli_in_t;

  typedef struct packed {
    logic signed [31:0] interpolated_value;
    logic [7:0]         base_index;
    logic               config_error;
  } tli_out_t;

endpackage

`default_nettype wire

// ===== hdl/table_linear_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// Table linear interpolator
// Piecewise linear interpolation over a written table of Q16.16 points,
// with a bisection search for the bracketing entry.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Word                     Handshake
//   -------  ---------  -----------------------  -----------------------
//   cfg      in         register index, data     cfg_valid_i / cfg_ready_o
//   in       in         tli_in_t (write/query)   in_valid_i  / in_ready_o
//   out      out        tli_out_t (result)       out_valid_o / out_ready_i
//
// A table write gives no result. A query runs a bisection search for the
// bracketing entry, one step per state, then a 35 step restoring divider.
// A query with a bad configuration skips the search and the divider.
// Reset sets both configuration registers to two; the table is not cleared.
// A finished result moves to the output register, freeing the input side.
//
`default_nettype none

module table_linear_interpolator_top
  import tli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [REG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire tli_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output tli_out_t                  out_data_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned RAM_W = 64;

  // Sequencer and configuration (control state).
  tli_state_e state_q, state_d;
  logic [CFG_W-1:0] points_q, points_d;
  logic [CFG_W-1:0] window_q, window_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  // Datapath registers.
  logic signed [31:0] query_q, query_d;
  logic asc_q, asc_d;
  logic [CFG_W-1:0] lo_q, lo_d;
  logic [CFG_W-1:0] hi_q, hi_d;
  logic [CFG_W-1:0] mid_q, mid_d;
  logic signed [31:0] x0_q, x0_d;
  logic signed [31:0] f0_q, f0_d;
  logic [31:0] dqm_q, dqm_d;
  logic [31:0] dfm_q, dfm_d;
  logic [31:0] dxm_q, dxm_d;
  logic neg_q, neg_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] rem_q, rem_d;
  logic [DIV_BITS-1:0] dvd_q, dvd_d;
  tli_out_t res_q, res_d;
  tli_out_t out_q;

  // Table RAM: abscissa in the upper half of the word, ordinate in the lower.
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [CFG_W-1:0] rd_idx;
  logic [RAM_W-1:0] ram_rdata;

  tli_ram #(
    .WIDTH(RAM_W),
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_table_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(AW'(rd_idx)),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Shared combinational terms
  // ---------------------------------------------------------------------
  logic in_fire;
  logic is_query;
  logic cfg_err;
  logic out_load;
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_f;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_query    = (in_data_i.opcode == OP_QUERY);
  assign rd_x        = $signed(ram_rdata[63:32]);
  assign rd_f        = $signed(ram_rdata[31:0]);
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign cfg_err = (window_q < WINDOW_MIN) || (points_q < WINDOW_MIN) ||
                   (window_q > points_q) || (32'(points_q) > 32'(TABLE_DEPTH));

  // Bisection step. Leaving ST_LAST the bracket opens as the whole table;
  // in ST_BISECT the word just read is compared against the query point.
  logic go_lo;
  logic [CFG_W-1:0] step_lo, step_hi, next_mid;
  logic [CFG_W:0] mid_sum;
  logic span_more;

  always_comb begin
    go_lo = ((query_q >= rd_x) == asc_q);
    if (state_q == ST_LAST) begin
      step_lo = '0;
      step_hi = points_q - CFG_W'(1);
    end else begin
      step_lo = go_lo ? mid_q : lo_q;
      step_hi = go_lo ? hi_q : mid_q;
    end
    mid_sum   = {1'b0, step_hi} + {1'b0, step_lo};
    next_mid  = mid_sum[CFG_W:1];
    span_more = (step_hi - step_lo) > CFG_W'(1);
  end

  // Window offset and clamp of the located index.
  logic [CFG_W-1:0] shift_amt, idx_shift, idx_lim, base_idx;

  always_comb begin
    shift_amt = (window_q - WINDOW_MIN) >> 1;
    idx_shift = (lo_q >= shift_amt) ? (lo_q - shift_amt) : '0;
    idx_lim   = points_q - window_q;
    base_idx  = (idx_shift > idx_lim) ? idx_lim : idx_shift;
  end

  // Differences of the bracketing pair; every magnitude fits in 32 bits.
  logic signed [32:0] dq, df, dx;
  logic [32:0] dq_neg, df_neg, dx_neg;

  always_comb begin
    dq = {query_q[31], query_q} - {x0_q[31], x0_q};
    df = {rd_f[31], rd_f} - {f0_q[31], f0_q};
    dx = {rd_x[31], rd_x} - {x0_q[31], x0_q};
    dq_neg = -dq;
    df_neg = -df;
    dx_neg = -dx;
  end

  // Quotient overflow test and one restoring division step.
  logic quot_big;
  logic [32:0] trial;
  logic fit;

  assign quot_big = ({3'b000, prod_q[63:35]} >= dxm_q);
  assign trial    = {rem_q, dvd_q[DIV_BITS-1]};
  assign fit      = (trial >= {1'b0, dxm_q});

  // Final sum of the lower ordinate and the signed quotient, saturated.
  logic signed [36:0] quot_s, sum_full;
  logic signed [31:0] sum_sat;

  always_comb begin
    quot_s   = $signed({2'b00, dvd_q});
    sum_full = $signed({{5{f0_q[31]}}, f0_q}) + (neg_q ? -quot_s : quot_s);
    if (dvd_q > QUOT_LIMIT) begin
      sum_sat = neg_q ? SAT_MIN : SAT_MAX;
    end else if (sum_full > 37'sh0_7FFF_FFFF) begin
      sum_sat = SAT_MAX;
    end else if (sum_full < 37'sh1F_8000_0000) begin
      sum_sat = SAT_MIN;
    end else begin
      sum_sat = sum_full[31:0];
    end
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && is_query) begin
          state_d = cfg_err ? ST_DONE : ST_FIRST;
        end
      end
      ST_FIRST:   state_d = ST_LAST;
      ST_LAST:    state_d = span_more ? ST_BISECT : ST_OFFSET;
      ST_BISECT:  state_d = span_more ? ST_BISECT : ST_OFFSET;
      ST_OFFSET:  state_d = ST_READ_LO;
      ST_READ_LO: state_d = ST_READ_HI;
      ST_READ_HI: state_d = (dx == '0) ? ST_DONE : ST_MUL;
      ST_MUL:     state_d = ST_CHECK;
      ST_CHECK:   state_d = quot_big ? ST_DONE : ST_DIV;
      ST_DIV:     state_d = (cnt_q == '0) ? ST_SUM : ST_DIV;
      ST_SUM:     state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath and control outputs
  // ---------------------------------------------------------------------
  always_comb begin
    points_d = points_q;
    window_d = window_q;
    cnt_d    = cnt_q;
    query_d  = query_q;
    asc_d    = asc_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    x0_d     = x0_q;
    f0_d     = f0_q;
    dqm_d    = dqm_q;
    dfm_d    = dfm_q;
    dxm_d    = dxm_q;
    neg_d    = neg_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    res_d    = res_q;
    rd_idx   = '0;

    ram_we    = in_fire && !is_query &&
                ({24'd0, in_data_i.entry_index} < 32'(TABLE_DEPTH));
    ram_waddr = AW'(in_data_i.entry_index);
    ram_wdata = {in_data_i.abscissa_value, in_data_i.ordinate_value};

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_POINTS_IN_USE: points_d = cfg_data_i;
        REG_WINDOW_POINTS: window_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        // Address 0 goes out now so that the first abscissa is ready next.
        query_d = in_data_i.query_point;
        res_d   = '{interpolated_value: '0, base_index: '0, config_error: 1'b1};
      end
      ST_FIRST: begin
        x0_d   = rd_x;
        rd_idx = points_q - CFG_W'(1);
      end
      ST_LAST: begin
        asc_d  = (rd_x >= x0_q);
        lo_d   = step_lo;
        hi_d   = step_hi;
        mid_d  = next_mid;
        rd_idx = next_mid;
      end
      ST_BISECT: begin
        lo_d   = step_lo;
        hi_d   = step_hi;
        mid_d  = next_mid;
        rd_idx = next_mid;
      end
      ST_OFFSET: begin
        lo_d   = base_idx;
        rd_idx = base_idx;
      end
      ST_READ_LO: begin
        x0_d   = rd_x;
        f0_d   = rd_f;
        rd_idx = lo_q + CFG_W'(1);
      end
      ST_READ_HI: begin
        dqm_d = dq[32] ? dq_neg[31:0] : dq[31:0];
        dfm_d = df[32] ? df_neg[31:0] : df[31:0];
        dxm_d = dx[32] ? dx_neg[31:0] : dx[31:0];
        neg_d = dq[32] ^ df[32] ^ dx[32];
        // Equal abscissas give the lower ordinate straight away.
        res_d = '{interpolated_value: f0_q, base_index: lo_q[7:0], config_error: 1'b0};
      end
      ST_MUL: begin
        prod_d = 64'(dqm_q) * 64'(dfm_q);
      end
      ST_CHECK: begin
        res_d = '{interpolated_value: (neg_q ? SAT_MIN : SAT_MAX),
                  base_index: lo_q[7:0], config_error: 1'b0};
        rem_d = {3'b000, prod_q[63:35]};
        dvd_d = prod_q[34:0];
        cnt_d = DIV_CNT_W'(DIV_BITS - 1);
      end
      ST_DIV: begin
        rem_d = fit ? 32'(trial - {1'b0, dxm_q}) : trial[31:0];
        dvd_d = {dvd_q[DIV_BITS-2:0], fit};
        cnt_d = cnt_q - DIV_CNT_W'(1);
      end
      ST_SUM: begin
        res_d = '{interpolated_value: sum_sat, base_index: lo_q[7:0], config_error: 1'b0};
      end
      ST_DONE: ;
      default: ;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      points_q    <= POINTS_RESET;
      window_q    <= WINDOW_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      points_q    <= points_d;
      window_q    <= window_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q <= query_d;
    asc_q   <= asc_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    x0_q    <= x0_d;
    f0_q    <= f0_d;
    dqm_q   <= dqm_d;
    dfm_q   <= dfm_d;
    dxm_q   <= dxm_d;
    neg_q   <= neg_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    res_q   <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/tli_ram.sv =====
// ----------------------------------------------------------------------------
// Table linear interpolator RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/tli_checker.sv =====
// ----------------------------------------------------------------------------
// Table linear interpolator checker
// Port level assertions on the interpolator, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_checker
  import tli_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 cfg_valid_i,
  input wire logic                 cfg_ready_o,
  input wire logic [REG_IDX_W-1:0] cfg_index_i,
  input wire logic [CFG_W-1:0]     cfg_data_i,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire tli_in_t              in_data_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire tli_out_t             out_data_o
);

  // A result word that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word withdrawn before it was taken");

  // A stalled result word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result word changed while stalled");

  // An accepted query keeps the input side busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode == OP_QUERY) |=> !in_ready_o)
    else $error("input accepted again straight after a query");

  // A fresh result only appears after the block has been busy with a query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a query in progress");

  // A configuration error result carries zero value and index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.config_error |->
      (out_data_o.interpolated_value == '0) && (out_data_o.base_index == '0))
    else $error("configuration error result with non-zero fields");

endmodule

bind table_linear_interpolator_top tli_checker u_tli_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_o(cfg_ready_o),
  .cfg_index_i(cfg_index_i),
  .cfg_data_i (cfg_data_i),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Table linear interpolator testbench
// Writes abscissa and ordinate tables, runs queries through the bisection and
// interpolation path under random idling on both channels, and checks every
// result word against a cycle-free prediction of the located index and of
// the saturated Q16.16 interpolated value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tli_pkg::*;

  localparam int unsigned DEPTH         = TABLE_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS  = 600;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 80;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned ERROR_PRINTS  = 40;

  typedef struct packed {
    tli_reg_e         idx;
    logic [CFG_W-1:0] data;
  } reg_write_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  tli_in_t              in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  tli_out_t             out_word;

  // Words waiting to be driven, register writes waiting, and the results
  // that accepted queries are owed.
  tli_in_t    pending_words[$];
  reg_write_t reg_writes[$];
  tli_out_t   expected_results[$];

  // Predictor state: table contents and registers as the block should hold them.
  logic signed [31:0] tbl_x [DEPTH];
  logic signed [31:0] tbl_f [DEPTH];
  logic [CFG_W-1:0]   cur_points = POINTS_RESET;
  logic [CFG_W-1:0]   cur_window = WINDOW_RESET;

  // Abscissas as pushed by the stimulus, used to aim queries at the table.
  logic signed [31:0] stim_x [DEPTH];

  bit          idle_on = 1'b1;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned items_pushed = 0;
  int unsigned n_queries = 0;
  int unsigned n_writes = 0;
  int unsigned n_checked = 0;
  int unsigned n_bad_cfg = 0;
  int unsigned n_settings = 0;

  table_linear_interpolator_top #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Expected result word of one query under the current registers and table.
  function automatic tli_out_t interpolate_query(input logic signed [31:0] q);
    tli_out_t           r;
    int unsigned        n, m, lo, hi, mid, shift, j;
    bit                 ascending, neg;
    longint             x0, x1, f0, f1, dq, df, dx, sum;
    longint unsigned    mdq, mdf, mdx, quot;
    r = '0;
    n = cur_points;
    m = cur_window;
    if (m < WINDOW_MIN || n < 2 || m > n || n > DEPTH) begin
      r.config_error = 1'b1;
      return r;
    end
    // Bisection over the first n entries; direction taken from the end points.
    ascending = (tbl_x[n-1] >= tbl_x[0]);
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (hi + lo) >> 1;
      if ((q >= tbl_x[mid]) == ascending) lo = mid;
      else hi = mid;
    end
    shift = (m - 2) >> 1;
    j = (lo >= shift) ? lo - shift : 0;
    if (j > n - m) j = n - m;
    x0 = tbl_x[j];
    x1 = tbl_x[j+1];
    f0 = tbl_f[j];
    f1 = tbl_f[j+1];
    if (x1 == x0) begin
      sum = f0;
    end else begin
      dq  = q - x0;
      df  = f1 - f0;
      dx  = x1 - x0;
      neg = ((dq < 0) != (df < 0)) != (dx < 0);
      mdq = (dq < 0) ? longint'(-dq) : dq;
      mdf = (df < 0) ? longint'(-df) : df;
      mdx = (dx < 0) ? longint'(-dx) : dx;
      quot = (mdq * mdf) / mdx;
      if (quot > QUOT_LIMIT) begin
        sum = neg ? SAT_MIN : SAT_MAX;
      end else begin
        sum = neg ? f0 - longint'(quot) : f0 + longint'(quot);
        if (sum > SAT_MAX) sum = SAT_MAX;
        if (sum < SAT_MIN) sum = SAT_MIN;
      end
    end
    r.interpolated_value = sum[31:0];
    r.base_index         = j[7:0];
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= ERROR_PRINTS) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Input driver. A write updates the predicted table at acceptance; a query
  // queues its predicted result word.
  always @(posedge clk_i or negedge rst_ni) begin : in_driver
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word  <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_word.opcode == OP_WRITE) begin
          if (in_word.entry_index < DEPTH) begin
            tbl_x[in_word.entry_index] = in_word.abscissa_value;
            tbl_f[in_word.entry_index] = in_word.ordinate_value;
          end
          n_writes++;
        end else begin
          expected_results.push_back(interpolate_query(in_word.query_point));
          n_queries++;
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
          gap_left <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver.
  always @(posedge clk_i or negedge rst_ni) begin : cfg_driver
    reg_write_t rw;
    if (!rst_ni) begin
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (tli_reg_e'(cfg_index))
          REG_POINTS_IN_USE: cur_points = cfg_data;
          REG_WINDOW_POINTS: cur_window = cfg_data;
          default: ;
        endcase
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_writes.size() != 0) begin
          rw = reg_writes.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= rw.idx;
          cfg_data  <= rw.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin : out_monitor
    tli_out_t    exp_w;
    int unsigned g;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result word %h with no query outstanding", out_word));
        end else begin
          exp_w = expected_results.pop_front();
          n_checked++;
          if (exp_w.config_error) n_bad_cfg++;
          if (out_word.interpolated_value !== exp_w.interpolated_value)
            flag_error($sformatf("interpolated_value %h, expected %h",
                                 out_word.interpolated_value, exp_w.interpolated_value));
          if (out_word.base_index !== exp_w.base_index)
            flag_error($sformatf("base_index %0d, expected %0d",
                                 out_word.base_index, exp_w.base_index));
          if (out_word.config_error !== exp_w.config_error)
            flag_error($sformatf("config_error %b, expected %b",
                                 out_word.config_error, exp_w.config_error));
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        g = draw_gap();
        stall_left <= (g != 0) ? g - 1 : 0;
        out_ready  <= (g == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed",
               cycle_count, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_write(input int unsigned idx, input logic signed [31:0] x,
                            input logic signed [31:0] f);
    tli_in_t w;
    w.opcode         = OP_WRITE;
    w.entry_index    = idx[7:0];
    w.abscissa_value = x;
    w.ordinate_value = f;
    w.query_point    = $urandom;
    stim_x[idx[7:0]] = x;
    pending_words.push_back(w);
    items_pushed++;
  endtask

  task automatic push_query(input logic signed [31:0] q);
    tli_in_t w;
    w.opcode         = OP_QUERY;
    w.entry_index    = $urandom;
    w.abscissa_value = $urandom;
    w.ordinate_value = $urandom;
    w.query_point    = q;
    pending_words.push_back(w);
    items_pushed++;
  endtask

  // Hold the sender until every word is taken and every result has come back.
  task automatic wait_drain();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(input int unsigned pts, input int unsigned win);
    reg_write_t rw;
    wait_drain();
    rw.idx  = REG_POINTS_IN_USE;
    rw.data = pts[CFG_W-1:0];
    reg_writes.push_back(rw);
    rw.idx  = REG_WINDOW_POINTS;
    rw.data = win[CFG_W-1:0];
    reg_writes.push_back(rw);
    do @(posedge clk_i);
    while (reg_writes.size() != 0 || cfg_valid);
    n_settings++;
  endtask

  // Writes entries 0 to n-1 with a monotone table (occasionally a scrambled
  // one). Step sizes vary from runs of equal abscissas to full-range spreads.
  task automatic fill_table(input int unsigned n);
    int unsigned style, i;
    bit          desc, walk_f;
    longint      x, f, step_max, step;
    style  = $urandom_range(0, 9);
    desc   = $urandom_range(0, 1);
    walk_f = $urandom_range(0, 1);
    if (style < 2) step_max = 3;
    else if (style < 5) step_max = 65536;
    else step_max = 64'd4294967295 / n;
    if (style >= 5 && style < 9) x = desc ? SAT_MAX : SAT_MIN;
    else x = int'($urandom);
    f = int'($urandom);
    for (i = 0; i < n; i++) begin
      if (style == 9) x = int'($urandom);
      push_write(i, x[31:0], f[31:0]);
      step = {$urandom, $urandom} % (step_max + 1);
      x = desc ? x - step : x + step;
      if (x > SAT_MAX) x = SAT_MAX;
      if (x < SAT_MIN) x = SAT_MIN;
      if (walk_f) begin
        f = f + (longint'(int'($urandom)) >>> 6);
        if (f > SAT_MAX) f = SAT_MAX;
        if (f < SAT_MIN) f = SAT_MIN;
      end else begin
        f = int'($urandom);
      end
    end
  endtask

  // Query point: mostly inside the table span, some on or next to an
  // abscissa, some anywhere, some at the extremes.
  function automatic logic signed [31:0] pick_query(input int unsigned n);
    longint          lo, hi;
    longint unsigned span, off;
    int unsigned     r;
    lo = (stim_x[0] < stim_x[n-1]) ? stim_x[0] : stim_x[n-1];
    hi = (stim_x[0] < stim_x[n-1]) ? stim_x[n-1] : stim_x[0];
    r  = $urandom_range(0, 99);
    if (r < 65) begin
      span = hi - lo + 1;
      off  = {$urandom, $urandom} % span;
      return 32'(lo + longint'(off));
    end
    if (r < 80) return stim_x[$urandom_range(0, n - 1)] + (int'($urandom_range(0, 2)) - 1);
    if (r < 90) return $urandom;
    return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
  endfunction

  task automatic random_traffic(input int unsigned count, input int unsigned n);
    int unsigned k, r, idx;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // Scramble one abscissa: the table may stop being monotone.
        push_write($urandom_range(0, n - 1), $urandom, $urandom);
      end else if (r < 12) begin
        idx = $urandom_range(0, n - 1);
        push_write(idx, stim_x[idx], $urandom);
      end else begin
        push_query(pick_query(n));
      end
      if ($urandom_range(0, 149) == 0) wait_drain();
    end
  endtask

  task automatic bad_setting(input int unsigned pts, input int unsigned win);
    int unsigned k;
    set_regs(pts, win);
    for (k = 0; k < 3; k++) push_query($urandom);
  endtask

  initial begin : stimulus
    int unsigned directed_items, pts, win, r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Two-point table at the reset setting first.
    set_regs(2, 2);
    // Widest possible span in both axes.
    push_write(0, SAT_MIN, SAT_MAX);
    push_write(1, SAT_MAX, SAT_MIN);
    push_query(SAT_MIN);
    push_query(SAT_MAX);
    push_query(32'sd0);
    // Equal abscissas give back the lower ordinate.
    push_write(0, 32'sh0005_0000, 32'sd100);
    push_write(1, 32'sh0005_0000, 32'sd200);
    push_query(32'sh0005_0000);
    push_query(-32'sd1);
    // Descending table.
    push_write(0, SAT_MAX, 32'sd0);
    push_write(1, SAT_MIN, 32'sh03E8_0000);
    push_query(32'sd0);
    push_query(SAT_MAX);
    // Steep segment, far extrapolation: saturation both ways.
    push_write(0, 32'sd0, 32'sd0);
    push_write(1, 32'sd1, SAT_MAX);
    push_query(SAT_MAX);
    push_query(SAT_MIN);

    // Window larger than the table is a configuration error.
    set_regs(2, 3);
    push_query(32'sd0);

    // Six points, window four: the shifted index clamps at zero at the low
    // end and at points minus window at the high end.
    set_regs(6, 4);
    push_write(2, 32'sd2, 32'sh0002_0000);
    push_write(3, 32'sd3, 32'sh0003_0000);
    push_write(4, 32'sd4, -32'sh0001_0000);
    push_write(5, 32'sd5, 32'sh7000_0000);
    push_query(32'sd0);
    push_query(32'sd3);
    push_query(SAT_MAX);
    directed_items = items_pushed;

    // Full table, then settings that reuse it, one of them without idling.
    set_regs(DEPTH, DEPTH);
    fill_table(DEPTH);
    random_traffic(40, DEPTH);
    idle_on = 1'b0;
    set_regs(DEPTH, 2);
    random_traffic(40, DEPTH);
    idle_on = 1'b1;
    set_regs(DEPTH, 129);
    random_traffic(30, DEPTH);

    // Unusable register values, the register extremes among them.
    bad_setting(0, 2);
    bad_setting(1, 2);
    bad_setting(5, 0);
    bad_setting(5, 1);
    bad_setting(5, 9);
    bad_setting(300, 2);
    bad_setting(511, 511);

    // Mostly small tables with fresh contents and random windows.
    while (items_pushed < directed_items + RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 6) pts = $urandom_range(2, 16);
      else if (r < 9) pts = $urandom_range(17, 64);
      else pts = 2;
      r = $urandom_range(0, 3);
      win = (r == 0) ? 2 : (r == 1) ? pts : $urandom_range(2, pts);
      set_regs(pts, win);
      idle_on = ($urandom_range(0, 3) != 0);
      fill_table(pts);
      random_traffic($urandom_range(20, 60), pts);
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d queries (%0d under unusable settings) and %0d table writes",
             n_queries, n_bad_cfg, n_writes);
    $display("over %0d register settings; %0d result words checked in %0d cycles.",
             n_settings, n_checked, cycle_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
